// ----- src/ets_pkg.sv -----
// Shared types, widths and constants for the Euler scale/rotate/translate
// model matrix core. No dependencies; every other file in src imports it.
package ets_pkg;

  // Field widths
  localparam int ANG_W  = 16;
  localparam int SC_W   = 16;
  localparam int POS_W  = 32;
  localparam int ELEM_W = 32;

  // Stream widths
  localparam int S_TDATA_W = 6 * ANG_W + 3 * POS_W;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 4 * ELEM_W;
  localparam int M_TUSER_W = 3;

  // CORDIC datapath
  localparam int TRIG_W    = 20;
  localparam int Z_W       = 21;
  localparam int CORD_ITER = 16;
  localparam int CORDIC_LAT = CORD_ITER + 1;

  localparam logic signed [TRIG_W-1:0] CORDIC_K   = TRIG_W'(39797);
  localparam logic signed [Z_W-1:0]    PI_Q16     = Z_W'(205887);
  localparam logic signed [Z_W-1:0]    HALF_PI_Q16 = Z_W'(102944);
  localparam logic signed [Z_W-1:0]    TWO_PI_Q16 = Z_W'(411775);

  localparam int ATAN_TAB [CORD_ITER] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // Rotation/scale datapath
  localparam int PAIR_W  = 34;
  localparam int SUM_W   = 56;
  localparam int RND_W   = 24;
  localparam int MUL_W   = 40;
  localparam int ROT_LAT = 5;
  localparam int PIPE_LAT = CORDIC_LAT + ROT_LAT;

  // Inverse squared scale divider
  localparam int SQ_W   = 31;
  localparam int QB     = 33;
  localparam int REM_W  = 32;
  localparam int BPS    = 2;
  localparam int DIV_ST = (QB + BPS - 1) / BPS;
  localparam int DIV_LAT = DIV_ST + 1;
  localparam int DIV_PAD = PIPE_LAT - DIV_LAT;

  localparam logic [ELEM_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [1:0]        COL_LAST = 2'd3;

  typedef struct packed {
    logic                          func;
    logic [2:0]                    zero;
    logic [2:0][POS_W-1:0]         pos;
    logic [2:0][ELEM_W-1:0]        inv;
    logic [2:0][2:0][ELEM_W-1:0]   rot;
  } mat_t;

endpackage

// ----- src/ets_cordic.sv -----
// Pipelined sine/cosine of one Q4.12 angle: range reduction stage plus one
// register stage per CORDIC iteration. Depends on ets_pkg.
module ets_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ets_pkg::ANG_W-1:0]  ang_i,
  output logic signed [ets_pkg::TRIG_W-1:0] sin_o,
  output logic signed [ets_pkg::TRIG_W-1:0] cos_o
);
  import ets_pkg::*;

  logic signed [Z_W-1:0]    a_w, a1_w, z0_d;
  logic                     neg0_d;
  logic signed [Z_W-1:0]    z_q   [CORD_ITER];
  logic signed [Z_W-1:0]    z_d   [CORD_ITER];
  logic                     neg_q [CORD_ITER+1];
  logic signed [TRIG_W-1:0] x_q   [CORD_ITER];
  logic signed [TRIG_W-1:0] y_q   [CORD_ITER];
  logic signed [TRIG_W-1:0] x_d   [CORD_ITER];
  logic signed [TRIG_W-1:0] y_d   [CORD_ITER];
  logic signed [TRIG_W-1:0] x_in  [CORD_ITER];
  logic signed [TRIG_W-1:0] y_in  [CORD_ITER];

  // fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
  always_comb begin
    a_w = Z_W'(ang_i) <<< 4;
    if (a_w > PI_Q16) begin
      a1_w = a_w - TWO_PI_Q16;
    end else if (a_w < -PI_Q16) begin
      a1_w = a_w + TWO_PI_Q16;
    end else begin
      a1_w = a_w;
    end
    if (a1_w > HALF_PI_Q16) begin
      z0_d   = a1_w - PI_Q16;
      neg0_d = 1'b1;
    end else if (a1_w < -HALF_PI_Q16) begin
      z0_d   = a1_w + PI_Q16;
      neg0_d = 1'b1;
    end else begin
      z0_d   = a1_w;
      neg0_d = 1'b0;
    end
  end

  always_comb begin
    x_in[0] = CORDIC_K;
    y_in[0] = '0;
    for (int i = 1; i < CORD_ITER; i++) begin
      x_in[i] = x_q[i-1];
      y_in[i] = y_q[i-1];
    end
    for (int i = 0; i < CORD_ITER; i++) begin
      if (!z_q[i][Z_W-1]) begin
        x_d[i] = x_in[i] - (y_in[i] >>> i);
        y_d[i] = y_in[i] + (x_in[i] >>> i);
        z_d[i] = z_q[i] - Z_W'(ATAN_TAB[i]);
      end else begin
        x_d[i] = x_in[i] + (y_in[i] >>> i);
        y_d[i] = y_in[i] - (x_in[i] >>> i);
        z_d[i] = z_q[i] + Z_W'(ATAN_TAB[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]   <= z0_d;
      neg_q[0] <= neg0_d;
      for (int i = 0; i < CORD_ITER; i++) begin
        x_q[i]     <= x_d[i];
        y_q[i]     <= y_d[i];
        neg_q[i+1] <= neg_q[i];
      end
      for (int i = 1; i < CORD_ITER; i++) begin
        z_q[i] <= z_d[i-1];
      end
    end
  end

  assign cos_o = neg_q[CORD_ITER] ? -x_q[CORD_ITER-1] : x_q[CORD_ITER-1];
  assign sin_o = neg_q[CORD_ITER] ? -y_q[CORD_ITER-1] : y_q[CORD_ITER-1];

endmodule

// ----- src/ets_rot.sv -----
// Rotation matrix from sines and cosines, scaled per column, rounded and
// saturated to Q16.16 over five register stages. Depends on ets_pkg.
module ets_rot (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   sx_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   cx_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   sy_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   cy_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   sz_i,
  input  logic signed [ets_pkg::TRIG_W-1:0]   cz_i,
  input  logic [2:0][ets_pkg::SC_W-1:0]       sc_i,
  output logic [2:0][2:0][ets_pkg::ELEM_W-1:0] rot_o
);
  import ets_pkg::*;

  localparam logic signed [SUM_W-1:0] RND48  = SUM_W'(64'sd2147483648);
  localparam logic signed [MUL_W-1:0] RND8   = MUL_W'(128);
  localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'(64'sd2147483647);
  localparam logic signed [MUL_W-1:0] SAT_LO = -SAT_HI - MUL_W'(1);

  // stage A: pair products
  logic signed [PAIR_W-1:0] czcy_a, sxsy_a, szcy_a, czsx_a, cxsy_a, szcx_a;
  logic signed [PAIR_W-1:0] cxcz_a, czsy_a, szsx_a, sysz_a, cycz_a, cxcy_a;
  logic signed [TRIG_W-1:0] sx_a, sy_a, sz_a, cy_a;
  logic [2:0][SC_W-1:0]     sc_a, sc_b, sc_c;
  // stage B: triple products and held pairs
  logic signed [SUM_W-1:0]  t0_b, t1_b, t2_b, t3_b;
  logic signed [PAIR_W-1:0] czcy_b, szcy_b, cxsy_b, szcx_b, cxcz_b, czsy_b;
  logic signed [PAIR_W-1:0] sysz_b, cxcy_b;
  logic signed [TRIG_W-1:0] sx_b;
  // stage C/D/E
  logic signed [SUM_W-1:0]  s_w   [3][3];
  logic signed [RND_W-1:0]  r16_q [3][3];
  logic signed [MUL_W-1:0]  m_q   [3][3];
  logic signed [MUL_W-1:0]  sh_w  [3][3];
  logic [ELEM_W-1:0]        e_q   [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czcy_a <= PAIR_W'(cz_i * cy_i);
      sxsy_a <= PAIR_W'(sx_i * sy_i);
      szcy_a <= PAIR_W'(sz_i * cy_i);
      czsx_a <= PAIR_W'(cz_i * sx_i);
      cxsy_a <= PAIR_W'(cx_i * sy_i);
      szcx_a <= PAIR_W'(sz_i * cx_i);
      cxcz_a <= PAIR_W'(cx_i * cz_i);
      czsy_a <= PAIR_W'(cz_i * sy_i);
      szsx_a <= PAIR_W'(sz_i * sx_i);
      sysz_a <= PAIR_W'(sy_i * sz_i);
      cycz_a <= PAIR_W'(cy_i * cz_i);
      cxcy_a <= PAIR_W'(cx_i * cy_i);
      sx_a   <= sx_i;
      sy_a   <= sy_i;
      sz_a   <= sz_i;
      cy_a   <= cy_i;
      sc_a   <= sc_i;

      t0_b   <= SUM_W'(sxsy_a * sz_a);
      t1_b   <= SUM_W'(czsx_a * sy_a);
      t2_b   <= SUM_W'(szsx_a * cy_a);
      t3_b   <= SUM_W'(cycz_a * sx_a);
      czcy_b <= czcy_a;
      szcy_b <= szcy_a;
      cxsy_b <= cxsy_a;
      szcx_b <= szcx_a;
      cxcz_b <= cxcz_a;
      czsy_b <= czsy_a;
      sysz_b <= sysz_a;
      cxcy_b <= cxcy_a;
      sx_b   <= sx_a;
      sc_b   <= sc_a;

      sc_c   <= sc_b;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          r16_q[k][j] <= RND_W'((s_w[k][j] + RND48) >>> 32);
          m_q[k][j]   <= MUL_W'(r16_q[k][j] * signed'(sc_c[k]));
          if (sh_w[k][j] > SAT_HI) begin
            e_q[k][j] <= SAT_MAX;
          end else if (sh_w[k][j] < SAT_LO) begin
            e_q[k][j] <= ~SAT_MAX;
          end else begin
            e_q[k][j] <= ELEM_W'(sh_w[k][j]);
          end
        end
      end
    end
  end

  // Q48 entries
  always_comb begin
    s_w[0][0] = (SUM_W'(czcy_b) <<< 16) - t0_b;
    s_w[0][1] = (SUM_W'(szcy_b) <<< 16) + t1_b;
    s_w[0][2] = -(SUM_W'(cxsy_b) <<< 16);
    s_w[1][0] = -(SUM_W'(szcx_b) <<< 16);
    s_w[1][1] = SUM_W'(cxcz_b) <<< 16;
    s_w[1][2] = SUM_W'(sx_b) <<< 32;
    s_w[2][0] = (SUM_W'(czsy_b) <<< 16) + t2_b;
    s_w[2][1] = (SUM_W'(sysz_b) <<< 16) - t3_b;
    s_w[2][2] = SUM_W'(cxcy_b) <<< 16;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        sh_w[k][j] = (m_q[k][j] + RND8) >>> 8;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        rot_o[k][j] = e_q[k][j];
      end
    end
  end

endmodule

// ----- src/ets_div.sv -----
// Pipelined restoring divider for round(2^32 / S^2), saturated to the
// largest positive Q16.16 value; a squaring stage then two quotient bits
// per stage. Depends on ets_pkg.
module ets_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [ets_pkg::SC_W-1:0]  sc_i,
  output logic [ets_pkg::ELEM_W-1:0]       inv_o
);
  import ets_pkg::*;

  logic [SQ_W-1:0]  sq0_q;
  logic [SQ_W-1:0]  sq_q  [DIV_ST];
  logic [REM_W-1:0] rem_q [DIV_ST];
  logic [QB-1:0]    quo_q [DIV_ST];
  logic [SQ_W-1:0]  sq_in  [DIV_ST];
  logic [REM_W-1:0] rem_in [DIV_ST];
  logic [QB-1:0]    quo_in [DIV_ST];
  logic [REM_W-1:0] rem_d  [DIV_ST];
  logic [QB-1:0]    quo_d  [DIV_ST];

  always_comb begin
    sq_in[0]  = sq0_q;
    rem_in[0] = '0;
    quo_in[0] = '0;
    for (int s = 1; s < DIV_ST; s++) begin
      sq_in[s]  = sq_q[s-1];
      rem_in[s] = rem_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
  end

  for (genvar s = 0; s < DIV_ST; s++) begin : g_st
    logic [QB-1:0]    num;
    logic [REM_W-1:0] rc [BPS+1];
    logic [QB-1:0]    qc [BPS+1];

    // dividend 2^32 + S^2/2 is a concatenation since S^2/2 < 2^30
    assign num   = {1'b1, 2'b00, sq_in[s][SQ_W-1:1]};
    assign rc[0] = rem_in[s];
    assign qc[0] = quo_in[s];

    for (genvar k = 0; k < BPS; k++) begin : g_bit
      localparam int Pos = s * BPS + k;
      if (Pos < QB) begin : g_on
        localparam int Bit = QB - 1 - Pos;
        logic [REM_W-1:0] shf;
        logic             ge;
        assign shf = {rc[k][REM_W-2:0], num[Bit]};
        assign ge  = shf >= REM_W'(sq_in[s]);
        assign rc[k+1] = ge ? shf - REM_W'(sq_in[s]) : shf;
        always_comb begin
          qc[k+1]      = qc[k];
          qc[k+1][Bit] = ge;
        end
      end else begin : g_off
        assign rc[k+1] = rc[k];
        assign qc[k+1] = qc[k];
      end
    end

    assign rem_d[s] = rc[BPS];
    assign quo_d[s] = qc[BPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq0_q <= SQ_W'(sc_i * sc_i);
      for (int s = 0; s < DIV_ST; s++) begin
        sq_q[s]  <= sq_in[s];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  // a zero divisor leaves the quotient all ones, which saturates as well
  assign inv_o = (|quo_q[DIV_ST-1][QB-1:ELEM_W-1]) ? SAT_MAX
               : {1'b0, quo_q[DIV_ST-1][ELEM_W-2:0]};

endmodule

// ----- src/ets_ser.sv -----
// Output stage: holds one finished matrix and sends it as four column
// transfers, column 3 marked last. Depends on ets_pkg.
module ets_ser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  ets_pkg::mat_t                   mat_i,
  output logic                            ready_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ets_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,  // elem0, elem1, elem2, elem3
  output logic [ets_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,  // column[1:0], zero_scale
  output logic                            m_axis_tlast_o
);
  import ets_pkg::*;

  mat_t              mat_q;
  logic              busy_q, busy_d;
  logic [1:0]        col_q, col_d;
  logic              xfer;
  logic [ELEM_W-1:0] e0, e1, e2, e3;
  logic              zf;

  assign xfer    = busy_q && m_axis_tready_i;
  assign ready_o = !busy_q || (xfer && col_q == COL_LAST);

  always_comb begin
    busy_d = busy_q;
    col_d  = col_q;
    if (load_i) begin
      busy_d = 1'b1;
      col_d  = '0;
    end else if (xfer) begin
      if (col_q == COL_LAST) begin
        busy_d = 1'b0;
      end else begin
        col_d = col_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else begin
      busy_q <= busy_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mat_q <= mat_i;
    end
  end

  always_comb begin
    if (col_q == COL_LAST) begin
      e0 = mat_q.pos[0];
      e1 = mat_q.pos[1];
      e2 = mat_q.pos[2];
      e3 = ONE_Q16;
      zf = 1'b0;
    end else begin
      e0 = mat_q.rot[col_q][0];
      e1 = mat_q.rot[col_q][1];
      e2 = mat_q.rot[col_q][2];
      e3 = mat_q.func ? mat_q.inv[col_q] : '0;
      zf = mat_q.func & mat_q.zero[col_q];
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {e3, e2, e1, e0};
  assign m_axis_tuser_o  = {zf, col_q};
  assign m_axis_tlast_o  = (col_q == COL_LAST);

endmodule

// ----- src/euler_trs_model_matrix_core.sv -----
// Top level of the Euler scale/rotate/translate model matrix core.
// Depends on ets_pkg, ets_cordic, ets_rot, ets_div and ets_ser.
//
// Takes three Q4.12 angles, three Q8.8 scales and a Q16.16 translation per
// input transfer and returns the 4x4 model matrix as four column transfers,
// column 0 first, the fourth marked with tlast. tuser on the input selects
// plain (0) or packed (1) mode; in packed mode elem3 of columns 0..2 holds
// 1/scale^2, saturated, with tuser[2] set when the scale was zero. The
// datapath is a 22-stage pipeline (17 CORDIC stages, 5 multiply/round
// stages, with the inverse-square divider running beside them) that
// takes a new input transfer while earlier ones are in flight. The output
// stage sends four transfers per matrix, which limits the sustained rate
// to one input transfer per four output transfers; the pipeline halts as a
// whole while a finished matrix waits for the output stage.
module euler_trs_model_matrix_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // rot_x, rot_y, rot_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
  input  logic [ets_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic [ets_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,  // func
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [ets_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,  // elem0, elem1, elem2, elem3
  output logic [ets_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,  // column[1:0], zero_scale
  output logic                            m_axis_tlast_o
);
  import ets_pkg::*;

  logic                     adv;
  logic                     ser_rdy;
  logic [PIPE_LAT-1:0]      vld_q;
  logic [2:0][SC_W-1:0]     sc_in;
  logic [2:0][POS_W-1:0]    pos_in;
  logic [2:0]               zero_in;
  logic [2:0][SC_W-1:0]     sc_dly   [CORDIC_LAT];
  logic [2:0][POS_W-1:0]    pos_dly  [PIPE_LAT];
  logic [2:0]               zero_dly [PIPE_LAT];
  logic                     func_dly [PIPE_LAT];
  logic [2:0][ELEM_W-1:0]   inv_w;
  logic [2:0][ELEM_W-1:0]   inv_dly  [DIV_PAD];
  logic signed [TRIG_W-1:0] sin_w [3];
  logic signed [TRIG_W-1:0] cos_w [3];
  logic [2:0][2:0][ELEM_W-1:0] rot_w;
  mat_t                     mat;

  // the whole pipeline advances unless a finished matrix is blocked
  assign adv             = !vld_q[PIPE_LAT-1] || ser_rdy;
  assign s_axis_tready_o = adv;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sc_in[a]   = s_axis_tdata_i[3*ANG_W + a*SC_W +: SC_W];
      pos_in[a]  = s_axis_tdata_i[3*ANG_W + 3*SC_W + a*POS_W +: POS_W];
      zero_in[a] = (sc_in[a] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_dly[0]   <= sc_in;
      pos_dly[0]  <= pos_in;
      zero_dly[0] <= zero_in;
      func_dly[0] <= s_axis_tuser_i[0];
      inv_dly[0]  <= inv_w;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        sc_dly[i] <= sc_dly[i-1];
      end
      for (int i = 1; i < PIPE_LAT; i++) begin
        pos_dly[i]  <= pos_dly[i-1];
        zero_dly[i] <= zero_dly[i-1];
        func_dly[i] <= func_dly[i-1];
      end
      for (int i = 1; i < DIV_PAD; i++) begin
        inv_dly[i] <= inv_dly[i-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    ets_cordic u_cordic (
      .clk_i (clk_i),
      .en_i  (adv),
      .ang_i (signed'(s_axis_tdata_i[a*ANG_W +: ANG_W])),
      .sin_o (sin_w[a]),
      .cos_o (cos_w[a])
    );

    ets_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .sc_i  (signed'(sc_in[a])),
      .inv_o (inv_w[a])
    );
  end

  ets_rot u_rot (
    .clk_i (clk_i),
    .en_i  (adv),
    .sx_i  (sin_w[0]),
    .cx_i  (cos_w[0]),
    .sy_i  (sin_w[1]),
    .cy_i  (cos_w[1]),
    .sz_i  (sin_w[2]),
    .cz_i  (cos_w[2]),
    .sc_i  (sc_dly[CORDIC_LAT-1]),
    .rot_o (rot_w)
  );

  always_comb begin
    mat.func = func_dly[PIPE_LAT-1];
    mat.zero = zero_dly[PIPE_LAT-1];
    mat.pos  = pos_dly[PIPE_LAT-1];
    mat.inv  = inv_dly[DIV_PAD-1];
    mat.rot  = rot_w;
  end

  ets_ser u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (adv && vld_q[PIPE_LAT-1]),
    .mat_i           (mat),
    .ready_o         (ser_rdy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- bench/euler_trs_model_matrix_core_test.sv -----
// Self-checking bench for the Euler scale/rotate/translate model matrix core.
// Depends on ets_pkg and euler_trs_model_matrix_core; predicts every column
// from the input transfer and compares each output transfer in order.
module euler_trs_model_matrix_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ets_pkg::*;

  typedef struct packed {
    logic        func;
    logic [15:0] rx, ry, rz, sx, sy, sz;
    logic [31:0] px, py, pz;
  } pose_t;

  typedef struct packed {
    logic [1:0]  col;
    logic [31:0] e0, e1, e2, e3;
    logic        zs;
    logic        last;
  } column_t;

  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic s_valid, s_ready, m_valid, m_ready, m_last;
  logic [S_TDATA_W-1:0] s_data;
  logic [S_TUSER_W-1:0] s_user;
  logic [M_TDATA_W-1:0] m_data;
  logic [M_TUSER_W-1:0] m_user;

  pose_t   pose_q[$];
  column_t column_q[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      calm = 0;      // no idling on either side
  bit      s_took = 0;    // input transfer at the last rising edge
  bit      stall_go = 0;  // start a long receiver stall
  int      hold_off = 0;  // receiver stall cycles remaining

  euler_trs_model_matrix_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void cordic_sincos(logic [15:0] raw, output longint s,
                                        output longint c);
    int atan [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    longint a, x, y, dx, dy;
    bit neg;
    a = longint'($signed(raw)) * 16;
    x = 39797; y = 0; neg = 0;
    if (a > 205887) a -= 411775;
    else if (a < -205887) a += 411775;
    if (a > 102944) begin a -= 205887; neg = 1; end
    else if (a < -102944) begin a += 205887; neg = 1; end
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (a >= 0) begin x -= dx; y += dy; a -= atan[i]; end
      else begin x += dx; y -= dy; a += atan[i]; end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [31:0] scale_entry(longint r48, longint sc);
    longint r16;
    r16 = fshr(r48 + (64'sd1 <<< 31), 32);
    return 32'(sat32(fshr(r16 * sc + 128, 8)));
  endfunction

  function automatic logic [31:0] inv_square(longint sc);
    longint unsigned sq, q;
    sq = longint'(sc * sc);
    q = ((64'd1 << 32) + sq / 2) / sq;
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  task automatic predict_matrix(pose_t p);
    longint sx, cx, sy, cy, sz, cz, o;
    longint sc [3];
    logic [31:0] e [3][4];
    bit zf [3];
    column_t c;
    o = 65536;
    cordic_sincos(p.rx, sx, cx);
    cordic_sincos(p.ry, sy, cy);
    cordic_sincos(p.rz, sz, cz);
    sc[0] = $signed(p.sx); sc[1] = $signed(p.sy); sc[2] = $signed(p.sz);
    e[0][0] = scale_entry(cz * cy * o - sx * sy * sz, sc[0]);
    e[0][1] = scale_entry(sz * cy * o + cz * sx * sy, sc[0]);
    e[0][2] = scale_entry(-cx * sy * o, sc[0]);
    e[1][0] = scale_entry(-sz * cx * o, sc[1]);
    e[1][1] = scale_entry(cx * cz * o, sc[1]);
    e[1][2] = scale_entry(sx * o * o, sc[1]);
    e[2][0] = scale_entry(cz * sy * o + sz * sx * cy, sc[2]);
    e[2][1] = scale_entry(sy * sz * o - cy * cz * sx, sc[2]);
    e[2][2] = scale_entry(cx * cy * o, sc[2]);
    for (int k = 0; k < 3; k++) begin
      e[k][3] = '0; zf[k] = 0;
      if (p.func) begin
        if (sc[k] == 0) begin e[k][3] = SAT_MAX; zf[k] = 1; end
        else e[k][3] = inv_square(sc[k]);
      end
      c = '{col: 2'(k), e0: e[k][0], e1: e[k][1], e2: e[k][2], e3: e[k][3],
            zs: zf[k], last: 1'b0};
      column_q.push_back(c);
    end
    c = '{col: COL_LAST, e0: p.px, e1: p.py, e2: p.pz, e3: ONE_Q16, zs: 1'b0,
          last: 1'b1};
    column_q.push_back(c);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.func = 1'($urandom_range(0, 1));
    p.rx = pick16(); p.ry = pick16(); p.rz = pick16();
    p.sx = pick16(); p.sy = pick16(); p.sz = pick16();
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    return p;
  endfunction

  // Driver: present the queue head, advance after each accepted transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((!s_valid || s_took) && pose_q.size() > 0 &&
          (calm || $urandom_range(0, 99) >= 15)) begin
        s_valid <= 1'b1;
        s_user <= pose_q[0].func;
        s_data <= {pose_q[0].pz, pose_q[0].py, pose_q[0].px, pose_q[0].sz,
                   pose_q[0].sy, pose_q[0].sx, pose_q[0].rz, pose_q[0].ry,
                   pose_q[0].rx};
      end else if (!s_valid || s_took) begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure plus one long stall on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_go) begin
        stall_go = 0;
        hold_off <= 300;
        m_ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= calm || $urandom_range(0, 99) >= 15;
      end
    end
  end

  // Monitor: record input transfers and compare each column transfer
  // against the oldest prediction.
  always @(posedge clk) begin
    column_t got, want;
    cycles <= cycles + 1;
    s_took = rst_n && s_valid && s_ready;
    if (s_took) begin
      predict_matrix(pose_q.pop_front());
    end
    if (rst_n && m_valid && m_ready) begin
      got = '{col: m_user[1:0], e0: m_data[31:0], e1: m_data[63:32],
              e2: m_data[95:64], e3: m_data[127:96], zs: m_user[2],
              last: m_last};
      if (column_q.size() == 0) begin
        $display("%0t: unexpected column %p", $realtime, got);
        errors <= errors + 1;
      end else begin
        want = column_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic pose_t make_pose(bit f, logic [15:0] r, logic [15:0] s,
                                      logic [31:0] pp);
    pose_t p;
    p = '{func: f, rx: r, ry: ~r, rz: r ^ 16'h5A5A, sx: s, sy: -s, sz: s ^ 16'h00FF,
          px: pp, py: ~pp, pz: pp ^ 32'h8000_0001};
    return p;
  endfunction

  initial begin
    pose_t p;
    rst_n = 0; s_valid = 0; s_data = '0; s_user = '0; m_ready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1;
    // Directed: angle, scale and position extremes in both modes; zero and
    // tiny scales for saturation of the packed term.
    pose_q.push_back(make_pose(0, 16'h0000, 16'h0100, 32'h0));
    pose_q.push_back(make_pose(1, 16'h0000, 16'h0100, 32'h0001_0000));
    pose_q.push_back(make_pose(1, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
    pose_q.push_back(make_pose(1, 16'h8000, 16'h8000, 32'h8000_0000));
    pose_q.push_back(make_pose(0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF));
    pose_q.push_back(make_pose(1, 16'h1922, 16'h0000, 32'h1234_5678));
    pose_q.push_back(make_pose(1, 16'h3244, 16'h0001, 32'h0));
    pose_q.push_back(make_pose(1, 16'hCDBC, 16'hFFFF, 32'h0));
    pose_q.push_back(make_pose(0, 16'h6488, 16'h0000, 32'h0));
    pose_q.push_back(make_pose(1, 16'h9B78, 16'h0010, 32'hDEAD_BEEF));
    p = make_pose(1, 16'h0C91, 16'h0200, 32'h0);
    p.sx = 0; p.sy = 16'h0100; p.sz = 0;
    pose_q.push_back(p);
    for (int i = 0; i < 120; i++) pose_q.push_back(random_pose());
    wait (pose_q.size() == 0);
    // Stall the receiver while the sender keeps offering.
    @(negedge clk) stall_go = 1;
    for (int i = 0; i < 60; i++) pose_q.push_back(random_pose());
    wait (pose_q.size() == 0);
    // Pause the sender until the pipeline drains.
    wait (column_q.size() == 0 && !s_valid);
    calm = 1;
    for (int i = 0; i < 120; i++) pose_q.push_back(random_pose());
    wait (pose_q.size() == 0);
    calm = 0;
    for (int i = 0; i < 160; i++) pose_q.push_back(random_pose());
    wait (pose_q.size() == 0 && !s_valid);
    wait (column_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/ets_pkg.sv
src/ets_cordic.sv
src/ets_rot.sv
src/ets_div.sv
src/ets_ser.sv
src/euler_trs_model_matrix_core.sv
bench/euler_trs_model_matrix_core_test.sv
